// ----- rtl/core/sled_pkg.sv -----
// Shared types, constants and helper functions of the WS2812 status LED encoder.
// No dependencies; every other file of the block uses it.
`default_nettype none

package sled_pkg;

  localparam int LED_COUNT_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int COLOR_W = 24;
  localparam int CFG_IDX_W = 2;
  localparam int TIME_W = 32;
  localparam int LEVEL_W = 7;
  localparam int TICKS_W = 4;

  localparam logic [TICKS_W-1:0] TICKS_ONE  = 4'd8;
  localparam logic [TICKS_W-1:0] TICKS_ZERO = 4'd4;

  localparam logic [6:0] LEVEL_MAX = 7'd100;
  localparam logic [6:0] LEVEL_MID = 7'd50;
  localparam logic [7:0] CHAN_FULL = 8'd255;

  localparam logic [3:0] STALE_ON_PHASES = 4'd8;
  localparam logic [3:0] NOCTL_ON_PHASES = 4'd2;

  // floor(t/100) = (t * DIV100_MUL) >> DIV100_SHIFT for any 32-bit t
  localparam logic [31:0] DIV100_MUL   = 32'd1374389535;
  localparam int          DIV100_SHIFT = 37;
  localparam int          Q100_W       = 26;
  // floor(q/10) = (q * DIV10_MUL) >> DIV10_SHIFT for any 32-bit q
  localparam logic [31:0] DIV10_MUL    = 32'hCCCCCCCD;
  localparam int          DIV10_SHIFT  = 35;
  localparam int          Q10_W        = 23;

  typedef enum logic [2:0] {
    MODE_OFF    = 3'd0,
    MODE_RGB    = 3'd1,
    MODE_READY  = 3'd2,
    MODE_LOWBAT = 3'd3,
    MODE_STALE  = 3'd4,
    MODE_NOCTL  = 3'd5,
    MODE_GRAD   = 3'd6
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] REG_READY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOWBAT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WARN   = 2'd2;

  typedef struct packed {
    logic [2:0]         mode;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [LEVEL_W-1:0] level;
  } cmd_t;

  // 255*l/50 = 5*l + l/10, valid for l up to 50
  function automatic logic [7:0] grad_chan(input logic [LEVEL_W-1:0] l);
    logic [14:0] p;
    logic [8:0]  s;
    p = 15'(l) * 15'd205;
    s = 9'(l) * 9'd5 + 9'(p[14:11]);
    return s[7:0];
  endfunction

  function automatic logic [TICKS_W-1:0] to_ticks(input logic b);
    return b ? TICKS_ONE : TICKS_ZERO;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sled_if.sv -----
// Valid/ready channel interfaces of the status LED encoder: command, config, result.
// Depends on sled_pkg for field widths.
`default_nettype none

interface sled_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    mode;
  logic [7:0]                    red;
  logic [7:0]                    green;
  logic [7:0]                    blue;
  logic [sled_pkg::LEVEL_W-1:0]  level;
  logic [sled_pkg::TIME_W-1:0]   time_ms;
  modport source (output valid, mode, red, green, blue, level, time_ms, input ready);
  modport sink   (input valid, mode, red, green, blue, level, time_ms, output ready);
endinterface

interface sled_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sled_pkg::CFG_IDX_W-1:0]  index;
  logic [sled_pkg::COLOR_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface sled_res_if;
  logic                           valid;
  logic                           ready;
  logic [sled_pkg::TICKS_W-1:0]   high_ticks_b7;
  logic [sled_pkg::TICKS_W-1:0]   high_ticks_b6;
  logic [sled_pkg::TICKS_W-1:0]   high_ticks_b5;
  logic [sled_pkg::TICKS_W-1:0]   high_ticks_b4;
  logic [sled_pkg::TICKS_W-1:0]   high_ticks_b3;
  logic [sled_pkg::TICKS_W-1:0]   high_ticks_b2;
  logic [sled_pkg::TICKS_W-1:0]   high_ticks_b1;
  logic [sled_pkg::TICKS_W-1:0]   high_ticks_b0;
  logic                           last_of_frame;
  modport source (output valid, high_ticks_b7, high_ticks_b6, high_ticks_b5, high_ticks_b4,
                  high_ticks_b3, high_ticks_b2, high_ticks_b1, high_ticks_b0,
                  last_of_frame, input ready);
  modport sink   (input valid, high_ticks_b7, high_ticks_b6, high_ticks_b5, high_ticks_b4,
                  high_ticks_b3, high_ticks_b2, high_ticks_b1, high_ticks_b0,
                  last_of_frame, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/sled_front.sv -----
// Front end: config registers, command intake and three-stage colour selection.
// Depends on sled_pkg and sled_if; feeds the colour queue.
`default_nettype none

module sled_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  sled_cmd_if.sink                          cmd,
  sled_cfg_if.sink                          cfg,
  output logic                              push_valid,
  input  wire logic                         push_ready,
  output logic [sled_pkg::COLOR_W-1:0]      push_data
);

  logic [sled_pkg::COLOR_W-1:0] ready_color;
  logic [sled_pkg::COLOR_W-1:0] low_battery_color;
  logic [sled_pkg::COLOR_W-1:0] warning_color;

  logic                         en;
  logic                         a_valid;
  logic                         b_valid;
  logic                         c_valid;
  sled_pkg::cmd_t               a_cmd;
  sled_pkg::cmd_t               b_cmd;
  sled_pkg::cmd_t               cmd_in;
  logic [sled_pkg::Q100_W-1:0]  a_q;
  logic [sled_pkg::Q100_W-1:0]  b_q;
  logic [sled_pkg::Q10_W-1:0]   b_qq;
  logic [63:0]                  p100;
  logic [57:0]                  p10;
  logic [sled_pkg::Q100_W-1:0]  tens;
  logic [3:0]                   phase;
  logic [sled_pkg::LEVEL_W-1:0] lv;
  logic [7:0]                   grad_r;
  logic [7:0]                   grad_g;
  logic [sled_pkg::COLOR_W-1:0] color_next;
  logic [sled_pkg::COLOR_W-1:0] c_color;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ready_color       <= '0;
      low_battery_color <= '0;
      warning_color     <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        sled_pkg::REG_READY:  ready_color       <= cfg.data;
        sled_pkg::REG_LOWBAT: low_battery_color <= cfg.data;
        sled_pkg::REG_WARN:   warning_color     <= cfg.data;
        default: ;
      endcase
    end
  end

  assign en        = !c_valid || push_ready;
  assign cmd.ready = en;

  always_comb begin
    cmd_in.mode  = cmd.mode;
    cmd_in.red   = cmd.red;
    cmd_in.green = cmd.green;
    cmd_in.blue  = cmd.blue;
    cmd_in.level = (cmd.level > sled_pkg::LEVEL_MAX) ? sled_pkg::LEVEL_MAX : cmd.level;
  end

  assign p100 = 64'(cmd.time_ms) * 64'(sled_pkg::DIV100_MUL);
  assign p10  = 58'(a_q) * 58'(sled_pkg::DIV10_MUL);

  always_comb begin
    tens   = 26'({b_qq, 3'b000}) + 26'({b_qq, 1'b0});
    phase  = 4'(b_q - tens);
    lv     = b_cmd.level;
    grad_g = (lv > sled_pkg::LEVEL_MID) ? sled_pkg::CHAN_FULL : sled_pkg::grad_chan(lv);
    grad_r = (lv < sled_pkg::LEVEL_MID) ? sled_pkg::CHAN_FULL
                                        : sled_pkg::grad_chan(sled_pkg::LEVEL_MAX - lv);
    case (b_cmd.mode)
      sled_pkg::MODE_RGB:    color_next = {b_cmd.red, b_cmd.green, b_cmd.blue};
      sled_pkg::MODE_READY:  color_next = ready_color;
      sled_pkg::MODE_LOWBAT: color_next = low_battery_color;
      sled_pkg::MODE_STALE:
        color_next = (phase < sled_pkg::STALE_ON_PHASES) ? warning_color : '0;
      sled_pkg::MODE_NOCTL:
        color_next = (phase < sled_pkg::NOCTL_ON_PHASES) ? warning_color : '0;
      sled_pkg::MODE_GRAD:   color_next = {grad_r, grad_g, 8'd0};
      default:               color_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else if (en) begin
      a_valid <= cmd.valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_cmd   <= cmd_in;
      a_q     <= p100[sled_pkg::DIV100_SHIFT +: sled_pkg::Q100_W];
      b_cmd   <= a_cmd;
      b_q     <= a_q;
      b_qq    <= p10[sled_pkg::DIV10_SHIFT +: sled_pkg::Q10_W];
      c_color <= color_next;
    end
  end

  assign push_valid = c_valid;
  assign push_data  = c_color;

`ifndef SYNTHESIS
  a_stall_holds_result: assert property (@(posedge clk) disable iff (rst)
    !en |-> (c_valid && !push_ready))
    else $error("front stalled without a blocked colour");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/sled_fifo.sv -----
// Short colour queue between front and back ends.
// Depends on sled_pkg for the default depth and width.
`default_nettype none

module sled_fifo #(
  parameter int DEPTH = sled_pkg::QUEUE_DEPTH_DEF,
  parameter int WIDTH = sled_pkg::COLOR_W
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic [WIDTH-1:0]      pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count above depth");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/sled_back.sv -----
// Back end: expands one queued colour into the strip frame, one byte per request.
// Depends on sled_pkg and sled_if; drains the colour queue.
`default_nettype none

module sled_back #(
  parameter int LED_COUNT = sled_pkg::LED_COUNT_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         pop_valid,
  output logic                              pop_ready,
  input  wire logic [sled_pkg::COLOR_W-1:0] pop_data,
  sled_res_if.source                        res
);

  localparam int LW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

  typedef enum logic [2:0] {
    CH_GREEN = 3'b001,
    CH_RED   = 3'b010,
    CH_BLUE  = 3'b100
  } chan_t;

  chan_t         chan;
  chan_t         chan_next;
  logic [LW-1:0] led;
  logic          load;
  logic          last;
  logic [7:0]    byte_val;
  logic          res_valid;
  logic [7:0]    res_byte;
  logic          res_last;

  assign load      = !res_valid || res.ready;
  assign last      = (led == LW'(LED_COUNT - 1)) && (chan == CH_BLUE);
  assign pop_ready = load && last;

  always_comb begin
    case (chan)
      CH_GREEN: begin
        byte_val  = pop_data[15:8];
        chan_next = CH_RED;
      end
      CH_RED: begin
        byte_val  = pop_data[23:16];
        chan_next = CH_BLUE;
      end
      CH_BLUE: begin
        byte_val  = pop_data[7:0];
        chan_next = CH_GREEN;
      end
      default: begin
        byte_val  = pop_data[15:8];
        chan_next = CH_GREEN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      chan      <= CH_GREEN;
      led       <= '0;
    end else if (load) begin
      res_valid <= pop_valid;
      if (pop_valid) begin
        chan <= chan_next;
        if (chan == CH_BLUE) begin
          led <= last ? '0 : led + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && pop_valid) begin
      res_byte <= byte_val;
      res_last <= last;
    end
  end

  assign res.valid         = res_valid;
  assign res.last_of_frame = res_last;
  assign res.high_ticks_b7 = sled_pkg::to_ticks(res_byte[7]);
  assign res.high_ticks_b6 = sled_pkg::to_ticks(res_byte[6]);
  assign res.high_ticks_b5 = sled_pkg::to_ticks(res_byte[5]);
  assign res.high_ticks_b4 = sled_pkg::to_ticks(res_byte[4]);
  assign res.high_ticks_b3 = sled_pkg::to_ticks(res_byte[3]);
  assign res.high_ticks_b2 = sled_pkg::to_ticks(res_byte[2]);
  assign res.high_ticks_b1 = sled_pkg::to_ticks(res_byte[1]);
  assign res.high_ticks_b0 = sled_pkg::to_ticks(res_byte[0]);

`ifndef SYNTHESIS
  a_pop_marks_last: assert property (@(posedge clk) disable iff (rst)
    (pop_valid && pop_ready) |=> (res_valid && res_last && chan == CH_GREEN && led == '0))
    else $error("frame end not aligned with queue pop");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/status_led_ws2812_encoder.sv -----
// Top level of the WS2812 status LED frame encoder.
// Depends on sled_pkg, sled_if, sled_front, sled_fifo and sled_back.
//
// Usage:
//   cmd  - one request selects a strip colour (mode, rgb, level, time_ms).
//   cfg  - register writes (ready, low-battery and warning colours), always ready;
//          write only while no frame is in flight.
//   res  - one request per frame byte: eight symbol high times, MSB first, in
//          green, red, blue order for every LED, last_of_frame on the final byte.
// The first byte of a frame is valid once its accepted command has passed the
// front end, a three-stage pipeline (two reciprocal multiplies for the blink
// phase, then colour selection), then the queue write and the output register.
// Throughput: 3*LED_COUNT bytes per command (48 at 16 LEDs), the back end
// emitting one byte per cycle while the receiver holds res.ready. The queue
// holds the colour being emitted and up to QUEUE_DEPTH-1 more, so commands are
// taken while bytes still drain.
// Reset clears the config colour registers, empties the pipeline and queue, and starts
// the next frame at the first LED. When the receiver stalls, the output byte
// holds, the queue fills, then the front end stalls and cmd.ready drops.
`default_nettype none

module status_led_ws2812_encoder #(
  parameter int LED_COUNT   = sled_pkg::LED_COUNT_DEF,
  parameter int QUEUE_DEPTH = sled_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  sled_cmd_if.sink  cmd,
  sled_cfg_if.sink  cfg,
  sled_res_if.source res
);

  logic                         push_valid;
  logic                         push_ready;
  logic [sled_pkg::COLOR_W-1:0] push_data;
  logic                         pop_valid;
  logic                         pop_ready;
  logic [sled_pkg::COLOR_W-1:0] pop_data;

  sled_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  sled_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (sled_pkg::COLOR_W)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  sled_back #(
    .LED_COUNT (LED_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .res       (res)
  );

endmodule

`default_nettype wire
